>>> hdl/sci_pkg.sv
// Shared constants, types and register codes of the segment-capsule intersect block.
package sci_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ADDR_W        = 5;
    localparam int COORD_W       = 32;
    localparam int RAD_W         = 31;
    localparam int VEC_W         = COORD_W + 1;
    localparam int DOT_W         = 2 * VEC_W + 2;
    localparam int WIDE_W        = 140;
    localparam int DIR_W         = 35;
    localparam int LEN_W         = 2 * DIR_W + 2;
    localparam int MUL_LW        = 32;
    localparam int MUL_LAT       = 3;

    typedef enum logic [2:0] {
        REG_SX,
        REG_SY,
        REG_SZ,
        REG_EX,
        REG_EY,
        REG_EZ,
        REG_RAD
    } t_reg;

    typedef struct packed {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] sz;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [COORD_W-1:0] ez;
        logic [RAD_W-1:0]   rad;
    } t_cfg;

endpackage

>>> hdl/sci_if.sv
// Stream interfaces for segment beats in and hit beats out.
interface sci_seg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_start_z;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] seg_end_z;

    modport source (output valid, seg_start_x, seg_start_y, seg_start_z,
                    seg_end_x, seg_end_y, seg_end_z, input ready);
    modport sink   (input valid, seg_start_x, seg_start_y, seg_start_z,
                    seg_end_x, seg_end_y, seg_end_z, output ready);
endinterface

interface sci_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink   (input valid, hit, output ready);
endinterface

>>> hdl/sci_dly.sv
// Enable-gated delay line for aligning side data with pipelined units.
module sci_dly #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    logic [W-1:0] r_sr [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_d = r_sr[N-1];
endmodule

>>> hdl/sci_mul.sv
// Pipelined signed multiplier built from 33x33 limb products, three register stages.
module sci_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [WA-1:0]   i_a,
    input  logic signed [WB-1:0]   i_b,
    output logic signed [WA+WB-1:0] o_p
);
    import sci_pkg::*;

    localparam int NA  = (WA + MUL_LW - 1) / MUL_LW;
    localparam int NB  = (WB + MUL_LW - 1) / MUL_LW;
    localparam int WP  = WA + WB;
    localparam int PPW = 2 * MUL_LW + 2;

    logic signed [NA*MUL_LW-1:0] a_ext;
    logic signed [NB*MUL_LW-1:0] b_ext;
    logic signed [MUL_LW:0]      a_limb [NA];
    logic signed [MUL_LW:0]      b_limb [NB];
    logic signed [PPW-1:0]       r_pp [NA][NB];
    logic signed [WP-1:0]        n_s0, n_s1, r_s0, r_s1, r_p;

    assign a_ext = (NA*MUL_LW)'(i_a);
    assign b_ext = (NB*MUL_LW)'(i_b);

    // top limb carries the sign, lower limbs are unsigned
    for (genvar gi = 0; gi < NA; gi++) begin : g_alimb
        if (gi == NA - 1) begin : g_top
            assign a_limb[gi] = $signed({a_ext[gi*MUL_LW+MUL_LW-1], a_ext[gi*MUL_LW +: MUL_LW]});
        end else begin : g_low
            assign a_limb[gi] = $signed({1'b0, a_ext[gi*MUL_LW +: MUL_LW]});
        end
    end
    for (genvar gj = 0; gj < NB; gj++) begin : g_blimb
        if (gj == NB - 1) begin : g_top
            assign b_limb[gj] = $signed({b_ext[gj*MUL_LW+MUL_LW-1], b_ext[gj*MUL_LW +: MUL_LW]});
        end else begin : g_low
            assign b_limb[gj] = $signed({1'b0, b_ext[gj*MUL_LW +: MUL_LW]});
        end
    end

    always_comb begin
        n_s0 = '0;
        n_s1 = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                if (((i + j) % 2) == 0) begin
                    n_s0 = n_s0 + (WP'(r_pp[i][j]) <<< ((i + j) * MUL_LW));
                end else begin
                    n_s1 = n_s1 + (WP'(r_pp[i][j]) <<< ((i + j) * MUL_LW));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= a_limb[i] * b_limb[j];
                end
            end
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_p  <= r_s0 + r_s1;
        end
    end

    assign o_p = r_p;
endmodule

>>> hdl/sci_div.sv
// Pipelined restoring divider giving a clamped fraction num/den in [0, 1], one bit per stage.
module sci_div #(
    parameter int FRAC = 16,
    parameter int W    = 140
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    output logic [FRAC:0]       o_q
);
    logic signed [W-1:0] r_n [FRAC+1];
    logic signed [W-1:0] r_d [FRAC+1];
    logic [FRAC-1:0]     r_q [FRAC+1];
    logic                r_z [FRAC+1];
    logic                r_o [FRAC+1];
    logic signed [W-1:0] n_t [FRAC];
    logic                n_ge [FRAC];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0] <= i_num;
            r_d[0] <= i_den;
            r_q[0] <= '0;
            r_z[0] <= (i_den <= 0) || (i_num <= 0);
            r_o[0] <= (i_num >= i_den);
        end
    end

    for (genvar gk = 1; gk <= FRAC; gk++) begin : g_step
        assign n_t[gk-1]  = r_n[gk-1] <<< 1;
        assign n_ge[gk-1] = (n_t[gk-1] >= r_d[gk-1]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[gk] <= n_ge[gk-1] ? (n_t[gk-1] - r_d[gk-1]) : n_t[gk-1];
                r_d[gk] <= r_d[gk-1];
                r_q[gk] <= {r_q[gk-1][FRAC-2:0], n_ge[gk-1]};
                r_z[gk] <= r_z[gk-1];
                r_o[gk] <= r_o[gk-1];
            end
        end
    end

    // non-positive operands give zero, a numerator at or above the denominator gives one
    assign o_q = r_z[FRAC] ? '0 :
                 r_o[FRAC] ? {1'b1, {FRAC{1'b0}}} : {1'b0, r_q[FRAC]};
endmodule

>>> hdl/sci_regs.sv
// APB register file holding the capsule axis and radius.
module sci_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sci_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output sci_pkg::t_cfg               o_cfg
);
    import sci_pkg::*;

    t_cfg r_cfg, n_cfg;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            case (paddr[ADDR_W-1:2])
                REG_SX:  n_cfg.sx  = pwdata;
                REG_SY:  n_cfg.sy  = pwdata;
                REG_SZ:  n_cfg.sz  = pwdata;
                REG_EX:  n_cfg.ex  = pwdata;
                REG_EY:  n_cfg.ey  = pwdata;
                REG_EZ:  n_cfg.ez  = pwdata;
                REG_RAD: n_cfg.rad = pwdata[RAD_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_SX:  prdata = r_cfg.sx;
            REG_SY:  prdata = r_cfg.sy;
            REG_SZ:  prdata = r_cfg.sz;
            REG_EX:  prdata = r_cfg.ex;
            REG_EY:  prdata = r_cfg.ey;
            REG_EZ:  prdata = r_cfg.ez;
            REG_RAD: prdata = {1'b0, r_cfg.rad};
            default: prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

>>> hdl/segment_capsule_intersect_core.sv
// Top level of the segment-versus-capsule hit test pipeline.
//
//   port     dir  handshake        beat contents
//   i_seg    in   valid/ready      segment endpoints, six signed Q15.16 coordinates
//   o_hit    out  valid/ready      hit flag
//   APB      in   psel/penable     capsule axis endpoints and radius
//
// One beat enters per cycle while the output beat is not stalled. The pipeline passes
// through four three-stage multipliers and the two dividers, which resolve one
// quotient bit per stage.
// Reset clears the valid line and the registers; the datapath holds no reset.
// A stalled output beat holds the whole pipeline, and i_seg.ready drops with it.
module segment_capsule_intersect_core #(
    parameter int FRAC_BITS = sci_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sci_seg_if.sink                     i_seg,
    sci_hit_if.source                   o_hit,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sci_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import sci_pkg::*;

    localparam int LAT     = 4 * MUL_LAT + 8 + FRAC_BITS;
    localparam int UVW_DLY = 2 * MUL_LAT + 5 + FRAC_BITS;
    localparam int SC_W    = FRAC_BITS + 2;
    localparam int PU_W    = VEC_W + SC_W;
    localparam int DA = 0, DB = 1, DC = 2, DD = 3, DE = 4;
    localparam logic signed [PU_W-1:0] BIAS = PU_W'((64'd1 << FRAC_BITS) - 64'd1);

    t_cfg cfg;
    logic en;
    logic [LAT-1:0] r_vld;

    sci_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // advance unless the output beat is stalled
    assign en          = !r_vld[LAT-1] || o_hit.ready;
    assign i_seg.ready = en;
    assign o_hit.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_seg.valid};
        end
    end

    // stage A: difference vectors
    logic signed [COORD_W-1:0] p0 [3], p1 [3], q0 [3], q1 [3];
    logic signed [VEC_W-1:0]   r_u [3], r_v [3], r_w [3];

    assign p0[0] = i_seg.seg_start_x;
    assign p0[1] = i_seg.seg_start_y;
    assign p0[2] = i_seg.seg_start_z;
    assign p1[0] = i_seg.seg_end_x;
    assign p1[1] = i_seg.seg_end_y;
    assign p1[2] = i_seg.seg_end_z;
    assign q0[0] = $signed(cfg.sx);
    assign q0[1] = $signed(cfg.sy);
    assign q0[2] = $signed(cfg.sz);
    assign q1[0] = $signed(cfg.ex);
    assign q1[1] = $signed(cfg.ey);
    assign q1[2] = $signed(cfg.ez);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i] <= VEC_W'(p1[i]) - VEC_W'(p0[i]);
                r_v[i] <= VEC_W'(q1[i]) - VEC_W'(q0[i]);
                r_w[i] <= VEC_W'(p0[i]) - VEC_W'(q0[i]);
            end
        end
    end

    // dot product terms
    logic signed [2*VEC_W-1:0] dp [5][3];

    for (genvar gi = 0; gi < 3; gi++) begin : g_dot
        sci_mul #(.WA(VEC_W), .WB(VEC_W)) u_maa (.i_clk(i_clk), .i_en(en),
            .i_a(r_u[gi]), .i_b(r_u[gi]), .o_p(dp[DA][gi]));
        sci_mul #(.WA(VEC_W), .WB(VEC_W)) u_mab (.i_clk(i_clk), .i_en(en),
            .i_a(r_u[gi]), .i_b(r_v[gi]), .o_p(dp[DB][gi]));
        sci_mul #(.WA(VEC_W), .WB(VEC_W)) u_mac (.i_clk(i_clk), .i_en(en),
            .i_a(r_v[gi]), .i_b(r_v[gi]), .o_p(dp[DC][gi]));
        sci_mul #(.WA(VEC_W), .WB(VEC_W)) u_mad (.i_clk(i_clk), .i_en(en),
            .i_a(r_u[gi]), .i_b(r_w[gi]), .o_p(dp[DD][gi]));
        sci_mul #(.WA(VEC_W), .WB(VEC_W)) u_mae (.i_clk(i_clk), .i_en(en),
            .i_a(r_v[gi]), .i_b(r_w[gi]), .o_p(dp[DE][gi]));
    end

    // stage C: sum the dot products
    logic signed [DOT_W-1:0] r_dot [5];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 5; j++) begin
                r_dot[j] <= DOT_W'(dp[j][0]) + DOT_W'(dp[j][1]) + DOT_W'(dp[j][2]);
            end
        end
    end

    // wide products for the determinant and numerators
    logic signed [2*DOT_W-1:0] wp [6];

    sci_mul #(.WA(DOT_W), .WB(DOT_W)) u_mw0 (.i_clk(i_clk), .i_en(en),
        .i_a(r_dot[DA]), .i_b(r_dot[DC]), .o_p(wp[0]));
    sci_mul #(.WA(DOT_W), .WB(DOT_W)) u_mw1 (.i_clk(i_clk), .i_en(en),
        .i_a(r_dot[DB]), .i_b(r_dot[DB]), .o_p(wp[1]));
    sci_mul #(.WA(DOT_W), .WB(DOT_W)) u_mw2 (.i_clk(i_clk), .i_en(en),
        .i_a(r_dot[DB]), .i_b(r_dot[DE]), .o_p(wp[2]));
    sci_mul #(.WA(DOT_W), .WB(DOT_W)) u_mw3 (.i_clk(i_clk), .i_en(en),
        .i_a(r_dot[DC]), .i_b(r_dot[DD]), .o_p(wp[3]));
    sci_mul #(.WA(DOT_W), .WB(DOT_W)) u_mw4 (.i_clk(i_clk), .i_en(en),
        .i_a(r_dot[DA]), .i_b(r_dot[DE]), .o_p(wp[4]));
    sci_mul #(.WA(DOT_W), .WB(DOT_W)) u_mw5 (.i_clk(i_clk), .i_en(en),
        .i_a(r_dot[DB]), .i_b(r_dot[DD]), .o_p(wp[5]));

    logic [5*DOT_W-1:0]      dot_pk, dot_dl;
    logic signed [DOT_W-1:0] dot_al [5];

    assign dot_pk = {r_dot[DE], r_dot[DD], r_dot[DC], r_dot[DB], r_dot[DA]};

    sci_dly #(.W(5*DOT_W), .N(MUL_LAT)) u_dly_dot (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (dot_pk),
        .o_d   (dot_dl)
    );

    for (genvar gj = 0; gj < 5; gj++) begin : g_dotal
        assign dot_al[gj] = $signed(dot_dl[gj*DOT_W +: DOT_W]);
    end

    // stage E: determinant and raw numerators
    logic signed [WIDE_W-1:0] r_edd, r_esn, r_etn;
    logic signed [DOT_W-1:0]  r_ed [5];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_edd <= WIDE_W'(wp[0]) - WIDE_W'(wp[1]);
            r_esn <= WIDE_W'(wp[2]) - WIDE_W'(wp[3]);
            r_etn <= WIDE_W'(wp[4]) - WIDE_W'(wp[5]);
            for (int j = 0; j < 5; j++) begin
                r_ed[j] <= dot_al[j];
            end
        end
    end

    // stage F: clamp the segment parameter against its range
    logic signed [WIDE_W-1:0] ea, eb, ec, ed, ee;
    logic signed [WIDE_W-1:0] n_fsn, n_fsd, n_ftn, n_ftd;
    logic signed [WIDE_W-1:0] r_fsn, r_fsd, r_ftn, r_ftd, r_fnd, r_fa, r_fb;

    assign ea = WIDE_W'(r_ed[DA]);
    assign eb = WIDE_W'(r_ed[DB]);
    assign ec = WIDE_W'(r_ed[DC]);
    assign ed = WIDE_W'(r_ed[DD]);
    assign ee = WIDE_W'(r_ed[DE]);

    always_comb begin
        n_fsn = r_esn;
        n_fsd = r_edd;
        n_ftn = r_etn;
        n_ftd = r_edd;
        if (r_edd == '0) begin
            // parallel: solve the capsule parameter alone
            n_fsn = '0;
            n_fsd = WIDE_W'(1);
            n_ftn = ee;
            n_ftd = ec;
        end else if (r_esn < 0) begin
            n_fsn = '0;
            n_ftn = ee;
            n_ftd = ec;
        end else if (r_esn > r_edd) begin
            n_fsn = r_edd;
            n_ftn = ee + eb;
            n_ftd = ec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fsn <= n_fsn;
            r_fsd <= n_fsd;
            r_ftn <= n_ftn;
            r_ftd <= n_ftd;
            r_fnd <= -ed;
            r_fa  <= ea;
            r_fb  <= eb;
        end
    end

    // stage G: clamp the capsule parameter and recompute the segment one
    logic signed [WIDE_W-1:0] fm, n_gsn, n_gsd, n_gtn;
    logic signed [WIDE_W-1:0] r_gsn, r_gsd, r_gtn, r_gtd;

    assign fm = r_fnd + r_fb;

    always_comb begin
        n_gsn = r_fsn;
        n_gsd = r_fsd;
        n_gtn = r_ftn;
        if (r_ftn < 0) begin
            n_gtn = '0;
            if (r_fnd < 0) begin
                n_gsn = '0;
            end else if (r_fnd > r_fa) begin
                n_gsn = r_fsd;
            end else begin
                n_gsn = r_fnd;
                n_gsd = r_fa;
            end
        end else if (r_ftn > r_ftd) begin
            n_gtn = r_ftd;
            if (fm < 0) begin
                n_gsn = '0;
            end else if (fm > r_fa) begin
                n_gsn = r_fsd;
            end else begin
                n_gsn = fm;
                n_gsd = r_fa;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gsn <= n_gsn;
            r_gsd <= n_gsd;
            r_gtn <= n_gtn;
            r_gtd <= r_ftd;
        end
    end

    logic [FRAC_BITS:0] sc, tc;

    sci_div #(.FRAC(FRAC_BITS), .W(WIDE_W)) u_sdiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_gsn),
        .i_den (r_gsd),
        .o_q   (sc)
    );

    sci_div #(.FRAC(FRAC_BITS), .W(WIDE_W)) u_tdiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_gtn),
        .i_den (r_gtd),
        .o_q   (tc)
    );

    // bring the direction and offset vectors up to the divider outputs
    logic [9*VEC_W-1:0]      uvw_pk, uvw_dl;
    logic [3*VEC_W-1:0]      w_dl2;
    logic signed [VEC_W-1:0] u_d [3], v_d [3], w_d [3];

    assign uvw_pk = {r_w[2], r_w[1], r_w[0], r_v[2], r_v[1], r_v[0], r_u[2], r_u[1], r_u[0]};

    sci_dly #(.W(9*VEC_W), .N(UVW_DLY)) u_dly_uvw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (uvw_pk),
        .o_d   (uvw_dl)
    );

    sci_dly #(.W(3*VEC_W), .N(MUL_LAT)) u_dly_w (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (uvw_dl[9*VEC_W-1:6*VEC_W]),
        .o_d   (w_dl2)
    );

    logic signed [SC_W-1:0]  sc_s, tc_s;
    logic signed [PU_W-1:0]  pu [3], pv [3], pu_b [3], pv_b [3];
    logic signed [DIR_W-1:0] q_u [3], q_v [3];
    logic signed [DIR_W-1:0] r_dir [3];
    logic signed [2*DIR_W-1:0] sq [3];

    assign sc_s = $signed({1'b0, sc});
    assign tc_s = $signed({1'b0, tc});

    for (genvar gi = 0; gi < 3; gi++) begin : g_dir
        assign u_d[gi] = $signed(uvw_dl[gi*VEC_W +: VEC_W]);
        assign v_d[gi] = $signed(uvw_dl[(3+gi)*VEC_W +: VEC_W]);
        assign w_d[gi] = $signed(w_dl2[gi*VEC_W +: VEC_W]);

        sci_mul #(.WA(VEC_W), .WB(SC_W)) u_mpu (.i_clk(i_clk), .i_en(en),
            .i_a(u_d[gi]), .i_b(sc_s), .o_p(pu[gi]));
        sci_mul #(.WA(VEC_W), .WB(SC_W)) u_mpv (.i_clk(i_clk), .i_en(en),
            .i_a(v_d[gi]), .i_b(tc_s), .o_p(pv[gi]));

        // rescale, truncating toward zero
        assign pu_b[gi] = pu[gi] + (pu[gi][PU_W-1] ? BIAS : '0);
        assign pv_b[gi] = pv[gi] + (pv[gi][PU_W-1] ? BIAS : '0);
        assign q_u[gi]  = DIR_W'(pu_b[gi] >>> FRAC_BITS);
        assign q_v[gi]  = DIR_W'(pv_b[gi] >>> FRAC_BITS);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dir[gi] <= DIR_W'(w_d[gi]) + q_u[gi] - q_v[gi];
            end
        end

        sci_mul #(.WA(DIR_W), .WB(DIR_W)) u_msq (.i_clk(i_clk), .i_en(en),
            .i_a(r_dir[gi]), .i_b(r_dir[gi]), .o_p(sq[gi]));
    end

    // squared radius follows the register, which the user only changes while idle; the block does not enforce this
    logic [2*RAD_W-1:0]      r_r2;
    logic signed [LEN_W-1:0] len, r2_s;
    logic                    r_hit;

    always_ff @(posedge i_clk) begin
        r_r2 <= cfg.rad * cfg.rad;
    end

    assign len  = LEN_W'(sq[0]) + LEN_W'(sq[1]) + LEN_W'(sq[2]);
    assign r2_s = $signed({{(LEN_W-2*RAD_W){1'b0}}, r_r2});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= (len <= r2_s);
        end
    end

    assign o_hit.hit = r_hit;
endmodule

>>> hdl/sci_chk.sv
// Port-level checker for the segment-capsule intersect core, bound to the top level.
module sci_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_hit
);
    // input back-pressure only comes from a blocked output beat
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a blocked output beat");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("output beat present right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output beat dropped while stalled");

    a_hold_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> $stable(out_hit))
        else $error("output payload changed while stalled");
endmodule

bind segment_capsule_intersect_core sci_chk u_sci_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (i_seg.ready),
    .out_valid (o_hit.valid),
    .out_ready (o_hit.ready),
    .out_hit   (o_hit.hit)
);
